[hdl/scb_pkg.sv]
`timescale 1ns / 1ps
package scb_pkg;

   localparam int NUM_CORES        = 4;
   localparam int BLOCKS_PER_CACHE = 8;
   localparam int CORE_BITS        = $clog2(NUM_CORES);
   localparam int SLOT_BITS        = $clog2(BLOCKS_PER_CACHE);
   localparam int NUM_BLOCKS       = NUM_CORES * BLOCKS_PER_CACHE;
   localparam int IDX_BITS         = $clog2(NUM_BLOCKS);
   localparam int ADDR_BITS        = 16;
   localparam int DATA_BITS        = 32;
   localparam int COUNT_BITS       = 32;
   localparam int INVAL_BITS       = 5;
   localparam int BYTES_PER_WRITE  = 8;
   localparam int QUEUE_DEPTH      = 2;
   localparam int PTR_BITS         = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS        = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CS_I = 3'd0,
      CS_S = 3'd1,
      CS_E = 3'd2,
      CS_O = 3'd3,
      CS_M = 3'd4
   } coh_state_type;

   typedef enum logic [1:0] {
      SRC_LOCAL  = 2'd0,
      SRC_PEER   = 2'd1,
      SRC_MEMORY = 2'd2,
      SRC_WRITE  = 2'd3
   } source_type;

   typedef enum logic {
      FUNC_READ  = 1'b0,
      FUNC_WRITE = 1'b1
   } func_type;

   typedef enum logic {
      MODE_MOESI = 1'b0,
      MODE_MESI  = 1'b1
   } mode_type;

   typedef struct packed {
      logic                 func;
      logic [1:0]           core_id;
      logic [2:0]           block_slot;
      logic [ADDR_BITS-1:0] address;
      logic [DATA_BITS-1:0] write_data;
      logic [DATA_BITS-1:0] memory_data;
   } req_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]  read_data;
      logic [1:0]            data_source;
      logic [2:0]            local_state_after;
      logic [INVAL_BITS-1:0] peers_invalidated;
      logic [COUNT_BITS-1:0] read_count;
      logic [COUNT_BITS-1:0] write_count;
      logic [COUNT_BITS-1:0] bytes_sent;
   } rsp_type;

   typedef struct packed {
      func_type             func;
      logic [IDX_BITS-1:0]  index;
      logic [ADDR_BITS-1:0] address;
      logic [DATA_BITS-1:0] write_data;
      logic [DATA_BITS-1:0] memory_data;
   } cmd_type;

endpackage

[hdl/scb_ram.sv]
`timescale 1ns / 1ps
module scb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

[hdl/scb_front.sv]
`timescale 1ns / 1ps
module scb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  scb_pkg::req_type req_payload,
   output logic             cmd_valid,
   output scb_pkg::cmd_type cmd,
   input  logic             cmd_take
);
   import scb_pkg::*;

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   cmd_type              classified;
   logic                 push_ok;
   logic                 take_ok;

   // The requester's core and slot fold into one flat block index.
   always_comb begin
      classified.func        = func_type'(req_payload.func);
      classified.index       = IDX_BITS'({req_payload.core_id[CORE_BITS-1:0],
                                          req_payload.block_slot[SLOT_BITS-1:0]});
      classified.address     = req_payload.address;
      classified.write_data  = req_payload.write_data;
      classified.memory_data = req_payload.memory_data;
   end

   assign req_full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign take_ok   = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = PTR_BITS'(wr_ptr_ff + 1'b1);
      end
      if (take_ok) begin
         rd_ptr_in = PTR_BITS'(rd_ptr_ff + 1'b1);
      end
      if (push_ok && !take_ok) begin
         count_in = QCNT_BITS'(count_ff + 1'b1);
      end else if (take_ok && !push_ok) begin
         count_in = QCNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

[hdl/scb_back.sv]
`timescale 1ns / 1ps
module scb_back (
   input  logic              clock,
   input  logic              reset,
   input  scb_pkg::mode_type mode,
   input  logic              cmd_valid,
   input  scb_pkg::cmd_type  cmd,
   output logic              cmd_take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output scb_pkg::rsp_type  rsp_payload
);
   import scb_pkg::*;

   typedef enum logic [1:0] {
      B_WAIT = 2'b01,
      B_DONE = 2'b10
   } back_fsm_type;

   typedef struct packed {
      source_type            source;
      coh_state_type         local_state;
      logic [INVAL_BITS-1:0] inval;
      logic [IDX_BITS-1:0]   index;
      logic [DATA_BITS-1:0]  memory_data;
   } pend_type;

   back_fsm_type          fsm_ff, fsm_in;
   logic [ADDR_BITS-1:0]  tag_ff [NUM_BLOCKS];
   logic [ADDR_BITS-1:0]  tag_in [NUM_BLOCKS];
   coh_state_type         state_ff [NUM_BLOCKS];
   coh_state_type         state_in [NUM_BLOCKS];
   logic [COUNT_BITS-1:0] reads_ff, reads_in;
   logic [COUNT_BITS-1:0] writes_ff, writes_in;
   logic [COUNT_BITS-1:0] bytes_ff, bytes_in;
   pend_type              pend_ff, pend_in;

   rsp_type               rspq_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   rq_wr_ff, rq_wr_in;
   logic [PTR_BITS-1:0]   rq_rd_ff, rq_rd_in;
   logic [QCNT_BITS-1:0]  rq_cnt_ff, rq_cnt_in;

   logic                  start;
   logic                  finish;
   logic                  pop_ok;
   logic [CORE_BITS-1:0]  my_core;
   coh_state_type         my_state;
   coh_state_type         peer_state;
   logic [NUM_BLOCKS-1:0] peer_match;
   logic [NUM_BLOCKS-1:0] supply_vec;
   logic                  found;
   logic [IDX_BITS-1:0]   pick;
   logic [INVAL_BITS-1:0] inval_count;
   rsp_type               result;
   logic [DATA_BITS-1:0]  ram_rdata;
   logic                  ram_we;
   logic [IDX_BITS-1:0]   ram_waddr;
   logic [DATA_BITS-1:0]  ram_wdata;
   logic [IDX_BITS-1:0]   ram_raddr;

   assign rsp_empty   = (rq_cnt_ff == '0);
   assign rsp_payload = rspq_ff[rq_rd_ff];
   assign pop_ok      = rsp_pop && !rsp_empty;
   assign start       = (fsm_ff == B_WAIT) && cmd_valid &&
                        (rq_cnt_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign finish      = (fsm_ff == B_DONE);
   assign cmd_take    = start;

   // Snoop: compare the address against every peer block at once.
   always_comb begin
      my_core = cmd.index[IDX_BITS-1:SLOT_BITS];
      my_state = state_ff[cmd.index];
      for (int k = 0; k < NUM_BLOCKS; k++) begin
         peer_match[k] = (tag_ff[k] == cmd.address) &&
                         (IDX_BITS'(k) >> SLOT_BITS) != IDX_BITS'(my_core);
         supply_vec[k] = peer_match[k] && (state_ff[k] != CS_I);
      end
      found = |supply_vec;
      pick = '0;
      for (int k = NUM_BLOCKS - 1; k >= 0; k--) begin
         if (supply_vec[k]) begin
            pick = IDX_BITS'(k);
         end
      end
      peer_state  = state_ff[pick];
      inval_count = INVAL_BITS'($countones(supply_vec));
   end

   always_comb begin
      fsm_in    = fsm_ff;
      tag_in    = tag_ff;
      state_in  = state_ff;
      reads_in  = reads_ff;
      writes_in = writes_ff;
      bytes_in  = bytes_ff;
      pend_in   = pend_ff;
      ram_we    = 1'b0;
      ram_waddr = cmd.index;
      ram_wdata = cmd.write_data;
      ram_raddr = cmd.index;
      if (start) begin
         fsm_in              = B_DONE;
         pend_in.index       = cmd.index;
         pend_in.memory_data = cmd.memory_data;
         pend_in.inval       = '0;
         if (cmd.func == FUNC_READ) begin
            reads_in = reads_ff + 1'b1;
            if (my_state != CS_I) begin
               pend_in.source = SRC_LOCAL;
            end else if (found) begin
               pend_in.source      = SRC_PEER;
               ram_raddr           = pick;
               tag_in[cmd.index]   = cmd.address;
               state_in[cmd.index] = CS_S;
               if (mode == MODE_MOESI && (peer_state == CS_E || peer_state == CS_O)) begin
                  state_in[pick] = CS_O;
               end else begin
                  state_in[pick] = CS_S;
               end
            end else begin
               pend_in.source      = SRC_MEMORY;
               ram_we              = 1'b1;
               ram_wdata           = cmd.memory_data;
               tag_in[cmd.index]   = cmd.address;
               state_in[cmd.index] = CS_E;
            end
         end else begin
            pend_in.source = SRC_WRITE;
            pend_in.inval  = inval_count;
            writes_in      = writes_ff + 1'b1;
            bytes_in       = bytes_ff + COUNT_BITS'(BYTES_PER_WRITE);
            ram_we         = 1'b1;
            for (int k = 0; k < NUM_BLOCKS; k++) begin
               if (peer_match[k]) begin
                  state_in[k] = CS_I;
               end
            end
            if (my_state == CS_S) begin
               state_in[cmd.index] = CS_M;
            end else if (my_state == CS_I) begin
               state_in[cmd.index] = (mode == MODE_MESI) ? CS_E : CS_O;
            end
         end
         pend_in.local_state = state_in[cmd.index];
      end else if (finish) begin
         fsm_in = B_WAIT;
         if (pend_ff.source == SRC_PEER) begin
            ram_we    = 1'b1;
            ram_waddr = pend_ff.index;
            ram_wdata = ram_rdata;
         end
      end
   end

   scb_ram #(
      .WIDTH(DATA_BITS),
      .DEPTH(NUM_BLOCKS)
   ) u_data_ram (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (ram_wdata),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   always_comb begin
      case (pend_ff.source)
         SRC_LOCAL, SRC_PEER: result.read_data = ram_rdata;
         SRC_MEMORY:          result.read_data = pend_ff.memory_data;
         default:             result.read_data = '0;
      endcase
      result.data_source       = pend_ff.source;
      result.local_state_after = pend_ff.local_state;
      result.peers_invalidated = pend_ff.inval;
      result.read_count        = reads_ff;
      result.write_count       = writes_ff;
      result.bytes_sent        = bytes_ff;
   end

   always_comb begin
      rq_wr_in  = rq_wr_ff;
      rq_rd_in  = rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (finish) begin
         rq_wr_in = PTR_BITS'(rq_wr_ff + 1'b1);
      end
      if (pop_ok) begin
         rq_rd_in = PTR_BITS'(rq_rd_ff + 1'b1);
      end
      if (finish && !pop_ok) begin
         rq_cnt_in = QCNT_BITS'(rq_cnt_ff + 1'b1);
      end else if (pop_ok && !finish) begin
         rq_cnt_in = QCNT_BITS'(rq_cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff    <= B_WAIT;
         reads_ff  <= '0;
         writes_ff <= '0;
         bytes_ff  <= '0;
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
         for (int k = 0; k < NUM_BLOCKS; k++) begin
            tag_ff[k]   <= '0;
            state_ff[k] <= CS_I;
         end
      end else begin
         fsm_ff    <= fsm_in;
         reads_ff  <= reads_in;
         writes_ff <= writes_in;
         bytes_ff  <= bytes_in;
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
         tag_ff    <= tag_in;
         state_ff  <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (finish) begin
         rspq_ff[rq_wr_ff] <= result;
      end
   end

endmodule

[hdl/snooping_coherence_bus_core.sv]
`timescale 1ns / 1ps
// Snooping coherence bus over four caches of eight blocks each.
// Requests enter through a queue port: a transaction is taken when req_push
// is high and req_full is low. Results leave through a queue port: the oldest
// result is on rsp_payload while rsp_empty is low and is removed when rsp_pop
// is high. Every request produces exactly one result, in request order.
// csr_write_enable with csr_write_data selects MOESI (0) or MESI (1); the user
// must write it only while no transaction is in flight; the block does not
// enforce this. A two-entry request queue decouples the front end from the
// execution unit. The execution unit takes a transaction in its wait state,
// doing the parallel tag snoop, priority pick and state update, and in its
// done state collects the data word from the block data RAM, which has one
// write and one registered read port. A new transaction is taken only after
// the previous one has finished. A two-entry result queue lets the execution
// unit go on while the receiver stalls; when it is full, execution waits and
// the request queue fills, raising req_full. Synchronous reset empties both
// queues, sets every block to I with a zero tag, clears the counters and
// selects MOESI.
module snooping_coherence_bus_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  scb_pkg::req_type req_payload,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output scb_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic             csr_write_data
);
   import scb_pkg::*;

   mode_type mode_ff, mode_in;
   logic     cmd_valid;
   cmd_type  cmd;
   logic     cmd_take;

   assign mode_in = csr_write_enable ? mode_type'(csr_write_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MOESI;
      end else begin
         mode_ff <= mode_in;
      end
   end

   scb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take)
   );

   scb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode_ff),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_take    (cmd_take),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

[hdl/scb_checker.sv]
`timescale 1ns / 1ps
module scb_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input scb_pkg::req_type req_payload,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input scb_pkg::rsp_type rsp_payload,
   input logic             csr_write_enable,
   input logic             csr_write_data
);
   import scb_pkg::*;

   logic unused_inputs;
   assign unused_inputs = req_push ^ req_full ^ (^req_payload) ^ csr_write_enable ^
                          csr_write_data;

   // Reset leaves no result waiting.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result visible right after reset");

   // A write transaction returns no data and leaves its own slot in E, O or M.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.data_source == SRC_WRITE) |->
         (rsp_payload.read_data == '0 && rsp_payload.local_state_after != CS_I &&
          rsp_payload.local_state_after != CS_S))
      else $error("write result malformed");

   // Only writes invalidate peers; fills land in E from memory and S from a peer.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_payload.data_source != SRC_WRITE) |->
         (rsp_payload.peers_invalidated == '0 &&
          (rsp_payload.data_source != SRC_MEMORY || rsp_payload.local_state_after == CS_E) &&
          (rsp_payload.data_source != SRC_PEER || rsp_payload.local_state_after == CS_S)))
      else $error("read result malformed");

   // Consecutive results advance the write count by one exactly when the newer one is a write.
   assert property (@(posedge clock) disable iff (reset)
      ((!rsp_empty && rsp_pop) ##1 !rsp_empty) |->
         (rsp_payload.write_count == $past(rsp_payload.write_count) +
            COUNT_BITS'(rsp_payload.data_source == SRC_WRITE)))
      else $error("write count out of sequence");

endmodule

bind snooping_coherence_bus_core scb_checker u_scb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_push         (req_push),
   .req_full         (req_full),
   .req_payload      (req_payload),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_payload      (rsp_payload),
   .csr_write_enable (csr_write_enable),
   .csr_write_data   (csr_write_data)
);
